/* hdl/pps_pkg.sv */
// Shared types, constants and sizes for the priority scheduler.
`default_nettype none
package pps_pkg;
   localparam int SLOTS   = 16;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;
   localparam int SUM_W   = 48;

   localparam logic FUNC_ARRIVE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;
   localparam logic KIND_ARRIVE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic [ID_W-1:0]    ident;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] remaining;
      logic [BURST_W-1:0] burst;
      logic [TIME_W-1:0]  arrival;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  idx;
      slot_rec_type       rec;
      logic [TIME_W-1:0]  age;
   } best_type;

   typedef struct packed {
      logic              item_kind;
      logic              accepted;
      logic              idle;
      logic [ID_W-1:0]   run_id;
      logic              finished;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] wait_time;
      logic [SUM_W-1:0]  sum_wait;
      logic [SUM_W-1:0]  sum_turnaround;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EXEC,
      ST_WAIT,
      ST_TOTAL,
      ST_RESPOND
   } state_type;
endpackage
`default_nettype wire

/* hdl/pps_ifs.sv */
// Handshake interfaces for the request and response channels.
`default_nettype none
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  proc_id;
   logic [15:0] burst_len;
   logic [7:0]  prio_level;
   modport source (output valid, func, proc_id, burst_len, prio_level, input ready);
   modport sink   (input valid, func, proc_id, burst_len, prio_level, output ready);
endinterface

interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic        accepted;
   logic        idle;
   logic [7:0]  run_id;
   logic        finished;
   logic [31:0] turnaround;
   logic [31:0] wait_time;
   logic [47:0] sum_wait;
   logic [47:0] sum_turnaround;
   modport source (output valid, item_kind, accepted, idle, run_id, finished, turnaround,
                   wait_time, sum_wait, sum_turnaround, input ready);
   modport sink   (input valid, item_kind, accepted, idle, run_id, finished, turnaround,
                   wait_time, sum_wait, sum_turnaround, output ready);
endinterface
`default_nettype wire

/* hdl/preemptive_priority_scheduler.sv */
// Top level: preemptive priority scheduler with slot table in a memory.
// Arrival item: after acceptance it passes to the respond state, where the response register
//   loads once the output is free. Tick item: the slot scan reads one memory entry per cycle,
//   followed by drain and update steps, and by wait-time and totals steps when the process
//   finishes. Next item taken in the cycle after the response loads.
// One item in flight at a time; a new item is taken while the response waits.
// Reset (synchronous): all slots free, time and totals zero, no response pending.
`default_nettype none
module preemptive_priority_scheduler (
   input wire logic clock,
   input wire logic reset,
   pps_req_if.sink   req,
   pps_rsp_if.source rsp
);
   import pps_pkg::*;

   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   slot_valid_ff;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic               cmp_vld_ff;
   logic [SLOT_W-1:0]  cmp_idx_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [SUM_W-1:0]   total_wait_ff, total_turn_ff;
   rsp_item_type       res_ff, res_in;
   rsp_item_type       out_ff, out_in;
   logic               rsp_valid_ff;

   logic               req_ready;
   logic               scan_rd;
   logic               scan_last;
   logic               pick_start;
   logic               out_free;
   logic               req_take;
   logic               arrive_ok;
   logic               has_free;
   logic [SLOT_W-1:0]  free_idx;
   logic               mem_wr_en;
   logic [SLOT_W-1:0]  mem_wr_addr;
   slot_rec_type       mem_wr_rec;
   logic [REC_W-1:0]   mem_rd_data;
   slot_rec_type       rd_rec;
   best_type           best;
   logic [BURST_W-1:0] rem_dec;
   logic [SUM_W:0]     wait_sum, turn_sum;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req_ready;
   assign scan_last = (rd_idx_ff == SLOT_W'(SLOTS - 1));
   assign rem_dec   = best.rec.remaining - BURST_W'(1);
   assign rd_rec    = slot_rec_type'(mem_rd_data);

   // lowest free slot
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign arrive_ok = req_take && (req.func == FUNC_ARRIVE) && has_free
                      && (req.burst_len != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req.func == FUNC_TICK) ? ST_SCAN : ST_RESPOND;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = (best.found && (rem_dec == '0)) ? ST_WAIT : ST_RESPOND;
         end
         ST_WAIT:  state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      scan_rd    = 1'b0;
      pick_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            pick_start = 1'b1;
         end
         ST_SCAN: scan_rd = 1'b1;
         ST_DRAIN, ST_EXEC, ST_WAIT, ST_TOTAL, ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = free_idx;
      mem_wr_rec  = '{ident: req.proc_id, prio: req.prio_level, remaining: req.burst_len,
                      burst: req.burst_len, arrival: now_ff};
      if (arrive_ok) begin
         mem_wr_en = 1'b1;
      end else if ((state_ff == ST_EXEC) && best.found) begin
         mem_wr_en            = 1'b1;
         mem_wr_addr          = best.idx;
         mem_wr_rec           = best.rec;
         mem_wr_rec.remaining = rem_dec;
      end
   end

   pps_slot_ram #(
      .DATA_W (REC_W),
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (REC_W'(mem_wr_rec)),
      .rd_en   (scan_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   pps_pick u_pick (
      .clock    (clock),
      .reset    (reset),
      .start    (pick_start),
      .cmp_en   (cmp_vld_ff),
      .cmp_idx  (cmp_idx_ff),
      .cmp_rec  (rd_rec),
      .now_time (now_ff),
      .best     (best)
   );

   assign wait_sum = {1'b0, total_wait_ff} + {{(SUM_W + 1 - TIME_W){1'b0}}, res_ff.wait_time};
   assign turn_sum = {1'b0, total_turn_ff} + {{(SUM_W + 1 - TIME_W){1'b0}}, res_ff.turnaround};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         now_ff        <= '0;
         total_wait_ff <= '0;
         total_turn_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= scan_rd && slot_valid_ff[rd_idx_ff];
         if (scan_rd) begin
            rd_idx_ff <= scan_last ? '0 : rd_idx_ff + SLOT_W'(1);
         end
         if (arrive_ok) begin
            slot_valid_ff[free_idx] <= 1'b1;
         end
         if (state_ff == ST_EXEC) begin
            now_ff <= now_ff + TIME_W'(1);
            if (best.found && (rem_dec == '0)) begin
               slot_valid_ff[best.idx] <= 1'b0;
            end
         end
         if (state_ff == ST_TOTAL) begin
            total_wait_ff <= wait_sum[SUM_W] ? SUM_MAX : wait_sum[SUM_W-1:0];
            total_turn_ff <= turn_sum[SUM_W] ? SUM_MAX : turn_sum[SUM_W-1:0];
         end
         if ((state_ff == ST_RESPOND) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result fields of the item in flight
   always_comb begin
      res_in = res_ff;
      if (req_take) begin
         res_in           = '0;
         res_in.item_kind = (req.func == FUNC_TICK) ? KIND_TICK : KIND_ARRIVE;
         res_in.accepted  = arrive_ok;
      end
      if (state_ff == ST_EXEC) begin
         res_in.idle       = !best.found;
         res_in.run_id     = best.found ? best.rec.ident : '0;
         res_in.finished   = best.found && (rem_dec == '0);
         res_in.turnaround = (best.found && (rem_dec == '0)) ? best.age + TIME_W'(1) : '0;
      end
      if (state_ff == ST_WAIT) begin
         res_in.wait_time = res_ff.turnaround
                            - {{(TIME_W - BURST_W){1'b0}}, best.rec.burst};
      end
   end

   always_comb begin
      out_in                = res_ff;
      out_in.sum_wait       = total_wait_ff;
      out_in.sum_turnaround = total_turn_ff;
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      res_ff     <= res_in;
      if ((state_ff == ST_RESPOND) && out_free) begin
         out_ff <= out_in;
      end
   end

   assign req.ready          = req_ready;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.item_kind      = out_ff.item_kind;
   assign rsp.accepted       = out_ff.accepted;
   assign rsp.idle           = out_ff.idle;
   assign rsp.run_id         = out_ff.run_id;
   assign rsp.finished       = out_ff.finished;
   assign rsp.turnaround     = out_ff.turnaround;
   assign rsp.wait_time      = out_ff.wait_time;
   assign rsp.sum_wait       = out_ff.sum_wait;
   assign rsp.sum_turnaround = out_ff.sum_turnaround;

   a_finish_is_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.finished) |-> (!rsp.idle && (rsp.item_kind == KIND_TICK)))
      else $error("finished item not a running tick");

   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((total_wait_ff >= $past(total_wait_ff))
                && (total_turn_ff >= $past(total_turn_ff))))
      else $error("running totals decreased");

   a_arrival_fills_slot: assert property (@(posedge clock) disable iff (reset)
      arrive_ok |=> ($countones(slot_valid_ff) == $past($countones(slot_valid_ff)) + 1))
      else $error("accepted arrival did not occupy a slot");

   a_scan_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("slot compare outside a scan");
endmodule
`default_nettype wire

/* hdl/pps_slot_ram.sv */
// Simple dual-port slot memory, registered read.
`default_nettype none
module pps_slot_ram #(
   parameter int DATA_W = 80,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* hdl/pps_pick.sv */
// Running best-candidate selector fed one slot record per cycle while cmp_en is high.
`default_nettype none
module pps_pick (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          cmp_en,
   input  wire logic [pps_pkg::SLOT_W-1:0]    cmp_idx,
   input  wire pps_pkg::slot_rec_type         cmp_rec,
   input  wire logic [pps_pkg::TIME_W-1:0]    now_time,
   output pps_pkg::best_type                  best
);
   import pps_pkg::*;

   best_type          best_ff;
   logic [TIME_W-1:0] age;
   logic              take;

   assign age  = now_time - cmp_rec.arrival;
   // lower prio number wins; on a tie the older entry; lowest slot on equal age
   assign take = cmp_en && (!best_ff.found
                 || (cmp_rec.prio < best_ff.rec.prio)
                 || ((cmp_rec.prio == best_ff.rec.prio) && (age > best_ff.age)));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         best_ff.found <= 1'b0;
      end else if (take) begin
         best_ff.found <= 1'b1;
      end
      if (take) begin
         best_ff.idx <= cmp_idx;
         best_ff.rec <= cmp_rec;
         best_ff.age <= age;
      end
   end

   assign best = best_ff;
endmodule
`default_nettype wire
